// File: sv/rvc_pkg.sv
// Shared types and encoding constants for the RV32C compressed execute block.
// No dependencies; every other file imports this package.
package rvc_pkg;

  // Command codes carried by each input request.
  localparam logic CMD_EXEC     = 1'b0;
  localparam logic CMD_LOAD_RET = 1'b1;

  // Quadrant codes, instruction bits 1:0.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Quadrant 0 funct3 codes.
  localparam logic [2:0] F3_ADDI4SPN = 3'd0;
  localparam logic [2:0] F3_LW       = 3'd2;
  localparam logic [2:0] F3_SW       = 3'd6;

  // Quadrant 1 funct3 codes.
  localparam logic [2:0] F3_ADDI     = 3'd0;
  localparam logic [2:0] F3_JAL      = 3'd1;
  localparam logic [2:0] F3_LI       = 3'd2;
  localparam logic [2:0] F3_LUI      = 3'd3;
  localparam logic [2:0] F3_MISC_ALU = 3'd4;
  localparam logic [2:0] F3_J        = 3'd5;
  localparam logic [2:0] F3_BEQZ     = 3'd6;
  localparam logic [2:0] F3_BNEZ     = 3'd7;

  // Quadrant 2 funct3 codes.
  localparam logic [2:0] F3_SLLI     = 3'd0;
  localparam logic [2:0] F3_LWSP     = 3'd2;
  localparam logic [2:0] F3_JR_MV    = 3'd4;
  localparam logic [2:0] F3_SWSP     = 3'd6;

  // Sub-opcodes of the quadrant 1 arithmetic group.
  localparam logic [1:0] F2_SRLI  = 2'd0;
  localparam logic [1:0] F2_SRAI  = 2'd1;
  localparam logic [1:0] F2_ANDI  = 2'd2;
  localparam logic [1:0] F2_ARITH = 2'd3;

  localparam logic [1:0] OP_SUB = 2'd0;
  localparam logic [1:0] OP_XOR = 2'd1;
  localparam logic [1:0] OP_OR  = 2'd2;
  localparam logic [1:0] OP_AND = 2'd3;

  // Fixed register numbers.
  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_RA   = 5'd1;
  localparam logic [4:0] REG_SP   = 5'd2;

  localparam int unsigned NUM_REGS = 32;

  typedef struct packed {
    logic        command;
    logic [15:0] instruction;
    logic [31:0] fetch_address;
    logic [31:0] load_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] next_address;
    logic        illegal;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] mem_address;
    logic [31:0] store_data;
  } out_item_t;

endpackage

// File: sv/rvc_if.sv
// Valid/ready channel interfaces for the input and result requests.
// Depends on rvc_pkg for the payload types.
interface rvc_in_if;
  import rvc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface rvc_out_if;
  import rvc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/rv32c_compressed_execute.sv
// RV32C compressed instruction execute block: register file, decode and execute.
// Depends on rvc_pkg and the channel interfaces in rvc_if.sv.
// A request passes from the input stage to the result register when that is free.
// Throughput: one request per cycle unless results stall; the register file read is
// registered in the input stage and the write of the executing request is forwarded.
// Reset: synchronous active-low; all registers read zero via per-entry valid bits,
// and no load is pending.
module rv32c_compressed_execute (
  input  logic     clk,
  input  logic     rst_n,
  rvc_in_if.sink   in_chan,
  rvc_out_if.source out_chan
);
  import rvc_pkg::*;

  // Register file storage and per-entry valid bits.
  logic [31:0]         rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] rf_valid_r;

  // Input stage.
  logic        s1_valid_r, s1_valid_nxt;
  in_item_t    s1_item_r;
  logic [31:0] rs_a_r, rs_b_r;

  // Result stage.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  // Pending load state.
  logic       load_pend_r, load_pend_nxt;
  logic [4:0] pend_dest_r, pend_dest_nxt;

  logic in_fire, out_free, exec_fire;

  // Read address decode for the incoming request.
  logic [15:0] in_ins;
  logic [4:0]  ra_addr, rb_addr;
  logic        fwd_a, fwd_b;

  // Execute results.
  out_item_t   res;
  logic        wr_en;
  logic [4:0]  wr_addr;
  logic [31:0] wr_data;
  logic        wr_go;
  logic        ld_set;
  logic [4:0]  ld_dest;

  // Handshake: the input stage refills whenever it is empty or drains this cycle.
  assign out_free      = !out_valid_r || out_chan.ready;
  assign exec_fire     = s1_valid_r && out_free;
  assign in_chan.ready = !s1_valid_r || out_free;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_item_r;

  assign in_ins = in_chan.payload.instruction;

  // Source register selection, following the RVC field placement.
  always_comb begin
    rb_addr = (in_ins[1:0] == QUAD_2) ? in_ins[6:2] : {2'b01, in_ins[4:2]};
    unique case (in_ins[1:0])
      QUAD_0: ra_addr = (in_ins[15:13] == F3_ADDI4SPN) ? REG_SP : {2'b01, in_ins[9:7]};
      QUAD_1: begin
        unique case (in_ins[15:13]) inside
          F3_ADDI, F3_LI, F3_LUI: ra_addr = in_ins[11:7];
          default:                ra_addr = {2'b01, in_ins[9:7]};
        endcase
      end
      QUAD_2: begin
        unique case (in_ins[15:13]) inside
          F3_LWSP, F3_SWSP: ra_addr = REG_SP;
          default:          ra_addr = in_ins[11:7];
        endcase
      end
      default: ra_addr = in_ins[11:7];
    endcase
  end

  assign fwd_a = wr_go && (wr_addr == ra_addr);
  assign fwd_b = wr_go && (wr_addr == rb_addr);

  // Register file read with forwarding of the write made in the same cycle.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_chan.payload;
      if (ra_addr == REG_ZERO || !(rf_valid_r[ra_addr] || fwd_a)) begin
        rs_a_r <= '0;
      end else if (fwd_a) begin
        rs_a_r <= wr_data;
      end else begin
        rs_a_r <= rf_mem[ra_addr];
      end
      if (rb_addr == REG_ZERO || !(rf_valid_r[rb_addr] || fwd_b)) begin
        rs_b_r <= '0;
      end else if (fwd_b) begin
        rs_b_r <= wr_data;
      end else begin
        rs_b_r <= rf_mem[rb_addr];
      end
    end
  end

  // Register file write port.
  always_ff @(posedge clk) begin
    if (wr_go) begin
      rf_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_valid_r <= '0;
    end else if (wr_go) begin
      rf_valid_r[wr_addr] <= 1'b1;
    end
  end

  // Decode and execute the request held in the input stage.
  always_comb begin
    logic [15:0] i;
    logic [31:0] a, b, pc, pc2;
    logic [31:0] imm6, bimm, jimm, wimm, uimm, sp16, luimm, lwsp_off, swsp_off;
    logic [4:0]  rfull, r2full, rp, r2p, sh;

    i      = s1_item_r.instruction;
    a      = rs_a_r;
    b      = rs_b_r;
    pc     = s1_item_r.fetch_address;
    pc2    = pc + 32'd2;
    rfull  = i[11:7];
    r2full = i[6:2];
    rp     = {2'b01, i[9:7]};
    r2p    = {2'b01, i[4:2]};
    sh     = i[6:2];

    imm6     = {{26{i[12]}}, i[12], i[6:2]};
    bimm     = {{23{i[12]}}, i[12], i[6:5], i[2], i[11:10], i[4:3], 1'b0};
    jimm     = {{20{i[12]}}, i[12], i[8], i[10:9], i[6], i[7], i[2], i[11], i[5:3], 1'b0};
    wimm     = {25'b0, i[5], i[12:10], i[6], 2'b0};
    uimm     = {22'b0, i[10:7], i[12:11], i[5], i[6], 2'b0};
    sp16     = {{22{i[12]}}, i[12], i[4:3], i[5], i[2], i[6], 4'b0};
    luimm    = {{14{i[12]}}, i[12], i[6:2], 12'b0};
    lwsp_off = {24'b0, i[3:2], i[12], i[6:4], 2'b0};
    swsp_off = {24'b0, i[8:7], i[12:9], 2'b0};

    res              = '0;
    res.next_address = pc2;
    wr_en            = 1'b0;
    wr_addr          = rfull;
    wr_data          = '0;
    ld_set           = 1'b0;
    ld_dest          = r2p;

    if (s1_item_r.command == CMD_LOAD_RET) begin
      // Load return: every result field reads zero.
      res.next_address = '0;
      wr_en            = load_pend_r;
      wr_addr          = pend_dest_r;
      wr_data          = s1_item_r.load_data;
    end else begin
      unique case (i[1:0])
        QUAD_0: begin
          unique case (i[15:13])
            F3_ADDI4SPN: begin
              if (uimm == '0) begin
                res.illegal = 1'b1;
              end else begin
                wr_en   = 1'b1;
                wr_addr = r2p;
                wr_data = a + uimm;
              end
            end
            F3_LW: begin
              res.mem_read    = 1'b1;
              res.mem_address = a + wimm;
              ld_set          = 1'b1;
              ld_dest         = r2p;
            end
            F3_SW: begin
              res.mem_write   = 1'b1;
              res.mem_address = a + wimm;
              res.store_data  = b;
            end
            default: res.illegal = 1'b1;
          endcase
        end
        QUAD_1: begin
          unique case (i[15:13])
            F3_ADDI: begin
              wr_en   = 1'b1;
              wr_data = a + imm6;
            end
            F3_JAL: begin
              wr_en            = 1'b1;
              wr_addr          = REG_RA;
              wr_data          = pc2;
              res.next_address = pc + jimm;
            end
            F3_LI: begin
              wr_en   = 1'b1;
              wr_data = imm6;
            end
            F3_LUI: begin
              if (rfull == REG_SP) begin
                // Stack pointer adjust; a zero offset is reserved.
                if (sp16 == '0) begin
                  res.illegal = 1'b1;
                end else begin
                  wr_en   = 1'b1;
                  wr_data = a + sp16;
                end
              end else if (!i[12] && i[6:2] == '0) begin
                res.illegal = 1'b1;
              end else begin
                wr_en   = 1'b1;
                wr_data = luimm;
              end
            end
            F3_MISC_ALU: begin
              wr_addr = rp;
              unique case (i[11:10])
                F2_SRLI: begin
                  res.illegal = i[12];
                  wr_en       = !i[12];
                  wr_data     = a >> sh;
                end
                F2_SRAI: begin
                  res.illegal = i[12];
                  wr_en       = !i[12];
                  wr_data     = $unsigned($signed(a) >>> sh);
                end
                F2_ANDI: begin
                  wr_en   = 1'b1;
                  wr_data = a & imm6;
                end
                default: begin
                  // Register-register group; the word forms are RV64 only.
                  res.illegal = i[12];
                  wr_en       = !i[12];
                  case (i[6:5])
                    OP_SUB:  wr_data = a - b;
                    OP_XOR:  wr_data = a ^ b;
                    OP_OR:   wr_data = a | b;
                    default: wr_data = a & b;
                  endcase
                end
              endcase
            end
            F3_J: res.next_address = pc + jimm;
            F3_BEQZ: begin
              if (a == '0) res.next_address = pc + bimm;
            end
            default: begin
              if (a != '0) res.next_address = pc + bimm;
            end
          endcase
        end
        QUAD_2: begin
          unique case (i[15:13])
            F3_SLLI: begin
              res.illegal = i[12];
              wr_en       = !i[12];
              wr_data     = a << r2full;
            end
            F3_LWSP: begin
              if (rfull == REG_ZERO) begin
                res.illegal = 1'b1;
              end else begin
                res.mem_read    = 1'b1;
                res.mem_address = a + lwsp_off;
                ld_set          = 1'b1;
                ld_dest         = rfull;
              end
            end
            F3_JR_MV: begin
              if (r2full == REG_ZERO) begin
                // Jump register, with link when bit 12 is set.
                if (rfull == REG_ZERO) begin
                  res.illegal = 1'b1;
                end else begin
                  res.next_address = {a[31:1], 1'b0};
                  wr_en            = i[12];
                  wr_addr          = REG_RA;
                  wr_data          = pc2;
                end
              end else begin
                wr_en   = 1'b1;
                wr_data = i[12] ? (a + b) : b;
              end
            end
            F3_SWSP: begin
              res.mem_write   = 1'b1;
              res.mem_address = a + swsp_off;
              res.store_data  = b;
            end
            default: res.illegal = 1'b1;
          endcase
        end
        default: res.illegal = 1'b1;
      endcase
    end
  end

  // Writes to x0 are discarded.
  assign wr_go = exec_fire && wr_en && (wr_addr != REG_ZERO);

  // Next-state logic for control registers.
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    load_pend_nxt = load_pend_r;
    pend_dest_nxt = pend_dest_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (exec_fire) begin
      s1_valid_nxt = 1'b0;
    end
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (exec_fire) begin
      if (s1_item_r.command == CMD_LOAD_RET) begin
        load_pend_nxt = 1'b0;
      end else if (ld_set) begin
        load_pend_nxt = 1'b1;
        pend_dest_nxt = ld_dest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      load_pend_r <= 1'b0;
      pend_dest_r <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      load_pend_r <= load_pend_nxt;
      pend_dest_r <= pend_dest_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_item_r <= res;
    end
  end

  // A result never requests a load and a store together.
  a_mem_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.mem_read && out_item_r.mem_write))
    else $error("result requests both a load and a store");

  // An illegal instruction issues no memory request and writes no register.
  a_illegal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && res.illegal) |-> (!res.mem_read && !res.mem_write && !wr_go))
    else $error("illegal instruction has side effects");

  // An executed load leaves its destination pending.
  a_load_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && res.mem_read) |=> (load_pend_r && pend_dest_r == $past(ld_dest)))
    else $error("load did not record its pending destination");

endmodule

// File: verif/tb_rv32c_compressed_execute.sv
// Self-checking testbench for the RV32C compressed execute block: a directed table,
// then random requests, scored against an in-bench model or a typed row's own result.
// Depends on rvc_pkg, the channel interfaces in rvc_if.sv and the block itself.
`timescale 1ns / 100ps

module tb_rv32c_compressed_execute;
  import rvc_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 1500;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned DRAIN_CYCLES    = 10;
  localparam int unsigned IDLE_PERCENT    = 30;
  localparam logic [31:0] INSN_BYTES      = 32'd2;

  // One row of the directed table; typed rows carry a hand-written result.
  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n;
  logic calm;

  rvc_in_if  in_if ();
  rvc_out_if out_if ();

  rv32c_compressed_execute dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Architectural state of the block as the testbench sees it.
  logic [31:0] arch_regs [NUM_REGS];
  logic [4:0]  load_dest;
  logic        load_busy;

  out_item_t   expected_results [$];
  vector_t     vectors [$];
  int unsigned mismatches;
  int unsigned cycle_count;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] reg_read(logic [4:0] n);
    return (n == REG_ZERO) ? 32'd0 : arch_regs[n];
  endfunction

  function automatic void reg_write(logic [4:0] n, logic [31:0] val);
    if (n != REG_ZERO) arch_regs[n] = val;
  endfunction

  // Executes one request against the state above and returns its result.
  function automatic out_item_t execute_compressed(in_item_t req);
    out_item_t   r;
    logic [15:0] w;
    logic [1:0]  quad;
    logic [2:0]  f3;
    logic        b12;
    logic [4:0]  rd_full, rs2_full, rd_c, rs2_c;
    logic [31:0] imm6, bimm, jimm, wimm, v, t, pc;
    r = '0;
    if (req.command == CMD_LOAD_RET) begin
      if (load_busy) begin
        reg_write(load_dest, req.load_data);
        load_busy = 1'b0;
      end
      return r;
    end

    w        = req.instruction;
    pc       = req.fetch_address;
    quad     = w[1:0];
    f3       = w[15:13];
    b12      = w[12];
    rd_full  = w[11:7];
    rs2_full = w[6:2];
    rd_c     = {2'b01, w[9:7]};
    rs2_c    = {2'b01, w[4:2]};
    imm6     = {{26{b12}}, b12, w[6:2]};
    bimm     = {{23{b12}}, b12, w[6:5], w[2], w[11:10], w[4:3], 1'b0};
    jimm     = {{20{b12}}, b12, w[8], w[10:9], w[6], w[7], w[2], w[11], w[5:3], 1'b0};
    wimm     = {25'd0, w[5], w[12:10], w[6], 2'b00};
    r.next_address = pc + INSN_BYTES;

    case (quad)
      QUAD_0: begin
        case (f3)
          F3_ADDI4SPN: begin
            t = {22'd0, w[10:7], w[12:11], w[5], w[6], 2'b00};
            if (t == 32'd0) r.illegal = 1'b1;
            else reg_write(rs2_c, reg_read(REG_SP) + t);
          end
          F3_LW: begin
            r.mem_read    = 1'b1;
            r.mem_address = reg_read(rd_c) + wimm;
            load_dest     = rs2_c;
            load_busy     = 1'b1;
          end
          F3_SW: begin
            r.mem_write   = 1'b1;
            r.mem_address = reg_read(rd_c) + wimm;
            r.store_data  = reg_read(rs2_c);
          end
          default: r.illegal = 1'b1;
        endcase
      end
      QUAD_1: begin
        case (f3)
          F3_ADDI: reg_write(rd_full, reg_read(rd_full) + imm6);
          F3_JAL: begin
            reg_write(REG_RA, pc + INSN_BYTES);
            r.next_address = pc + jimm;
          end
          F3_LI: reg_write(rd_full, imm6);
          F3_LUI: begin
            if (rd_full == REG_SP) begin
              // Stack adjust shares the slot; a zero amount is reserved.
              t = {{22{b12}}, b12, w[4:3], w[5], w[2], w[6], 4'd0};
              if (t == 32'd0) r.illegal = 1'b1;
              else reg_write(REG_SP, reg_read(REG_SP) + t);
            end else if (!b12 && w[6:2] == 5'd0) begin
              r.illegal = 1'b1;
            end else begin
              reg_write(rd_full, {{14{b12}}, b12, w[6:2], 12'd0});
            end
          end
          F3_MISC_ALU: begin
            v = reg_read(rd_c);
            case (w[11:10])
              F2_SRLI: begin
                if (b12) r.illegal = 1'b1;
                else reg_write(rd_c, v >> rs2_full);
              end
              F2_SRAI: begin
                if (b12) r.illegal = 1'b1;
                else reg_write(rd_c, 32'($signed(v) >>> rs2_full));
              end
              F2_ANDI: reg_write(rd_c, v & imm6);
              default: begin
                // With bit 12 set these are the 64-bit word forms.
                if (b12) r.illegal = 1'b1;
                else begin
                  t = reg_read(rs2_c);
                  case (w[6:5])
                    OP_SUB:  reg_write(rd_c, v - t);
                    OP_XOR:  reg_write(rd_c, v ^ t);
                    OP_OR:   reg_write(rd_c, v | t);
                    default: reg_write(rd_c, v & t);
                  endcase
                end
              end
            endcase
          end
          F3_J: r.next_address = pc + jimm;
          F3_BEQZ: if (reg_read(rd_c) == 32'd0) r.next_address = pc + bimm;
          default: if (reg_read(rd_c) != 32'd0) r.next_address = pc + bimm;
        endcase
      end
      QUAD_2: begin
        case (f3)
          F3_SLLI: begin
            if (b12) r.illegal = 1'b1;
            else reg_write(rd_full, reg_read(rd_full) << rs2_full);
          end
          F3_LWSP: begin
            if (rd_full == REG_ZERO) r.illegal = 1'b1;
            else begin
              r.mem_read    = 1'b1;
              r.mem_address = reg_read(REG_SP) + {24'd0, w[3:2], b12, w[6:4], 2'b00};
              load_dest     = rd_full;
              load_busy     = 1'b1;
            end
          end
          F3_JR_MV: begin
            if (rs2_full == REG_ZERO) begin
              if (rd_full == REG_ZERO) r.illegal = 1'b1;
              else begin
                // The target is read before the link register is written.
                t = reg_read(rd_full) & ~32'd1;
                if (b12) reg_write(REG_RA, pc + INSN_BYTES);
                r.next_address = t;
              end
            end else if (b12) begin
              reg_write(rd_full, reg_read(rd_full) + reg_read(rs2_full));
            end else begin
              reg_write(rd_full, reg_read(rs2_full));
            end
          end
          F3_SWSP: begin
            r.mem_write   = 1'b1;
            r.mem_address = reg_read(REG_SP) + {24'd0, w[8:7], w[12:9], 2'b00};
            r.store_data  = reg_read(rs2_full);
          end
          default: r.illegal = 1'b1;
        endcase
      end
      default: r.illegal = 1'b1;
    endcase
    return r;
  endfunction

  task automatic add_vector(input logic cmd, input logic [15:0] ins, input logic [31:0] pc,
                            input logic [31:0] ld, input bit typed,
                            input logic [31:0] npc, input logic ill);
    vector_t v;
    v.stim  = '{command: cmd, instruction: ins, fetch_address: pc, load_data: ld};
    v.typed = typed;
    v.want  = '{next_address: npc, illegal: ill, mem_read: 1'b0, mem_write: 1'b0,
                mem_address: 32'd0, store_data: 32'd0};
    vectors.push_back(v);
  endtask

  // Random request: mostly decodable instructions with random fields, some load
  // returns and some raw 16-bit noise.
  function automatic in_item_t random_request();
    in_item_t    it;
    int unsigned pick, k;
    logic [1:0]  quad;
    logic [2:0]  f3;
    it.fetch_address = $urandom;
    pick = $urandom_range(3);
    it.load_data = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF :
                   (pick == 2) ? 32'h8000_0000 : 32'($urandom);
    if ($urandom_range(3) != 0) it.load_data = $urandom;
    it.command     = CMD_EXEC;
    it.instruction = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 12) begin
      it.command = CMD_LOAD_RET;
    end else if (pick >= 22) begin
      k = $urandom_range(14);
      if (k < 3) begin
        quad = QUAD_0;
        f3   = (k == 0) ? F3_ADDI4SPN : (k == 1) ? F3_LW : F3_SW;
      end else if (k < 11) begin
        quad = QUAD_1;
        f3   = 3'(k - 3);
      end else begin
        quad = QUAD_2;
        f3   = (k == 11) ? F3_SLLI : (k == 12) ? F3_LWSP : (k == 13) ? F3_JR_MV : F3_SWSP;
      end
      it.instruction = {f3, 11'($urandom), quad};
    end
    return it;
  endfunction

  // Offers one request, holds it until taken and records what it should produce.
  task automatic send_request(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t predicted;
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk); while (!in_if.ready);
    predicted = execute_compressed(it);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic log_mismatch(input string what);
    if (mismatches < 10) $display("mismatch: %s", what);
    mismatches++;
  endtask

  // Result side: random back-pressure, quiet during the calm stretch.
  always @(posedge clk) begin
    out_if.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Score each accepted result against the oldest expectation.
  always @(posedge clk) begin : score_results
    out_item_t want, got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (expected_results.size() == 0) begin
        log_mismatch($sformatf("result with nothing expected: %p", got));
      end else begin
        want = expected_results.pop_front();
        if (got.next_address !== want.next_address)
          log_mismatch($sformatf("next_address expected %h got %h",
                                 want.next_address, got.next_address));
        if (got.illegal !== want.illegal)
          log_mismatch($sformatf("illegal expected %b got %b", want.illegal, got.illegal));
        if (got.mem_read !== want.mem_read)
          log_mismatch($sformatf("mem_read expected %b got %b", want.mem_read, got.mem_read));
        if (got.mem_write !== want.mem_write)
          log_mismatch($sformatf("mem_write expected %b got %b",
                                 want.mem_write, got.mem_write));
        if (got.mem_address !== want.mem_address)
          log_mismatch($sformatf("mem_address expected %h got %h",
                                 want.mem_address, got.mem_address));
        if (got.store_data !== want.store_data)
          log_mismatch($sformatf("store_data expected %h got %h",
                                 want.store_data, got.store_data));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_rv32c_compressed_execute: FAIL");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    rst_n          = 1'b0;
    calm           = 1'b0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    out_if.ready   = 1'b0;
    mismatches     = 0;
    cycle_count    = 0;
    load_dest      = REG_ZERO;
    load_busy      = 1'b0;
    foreach (arch_regs[i]) arch_regs[i] = 32'd0;

    // Directed table. Typed rows: load returns, illegal forms and one hint.
    // Load return with nothing pending, all fields at their top.
    add_vector(CMD_LOAD_RET, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd0, 1'b0);
    // All-zero word: stack-pointer add with zero immediate is reserved.
    add_vector(CMD_EXEC, 16'h0000, 32'h0000_0000, 32'd0, 1, 32'h0000_0002, 1'b1);
    // Quadrant three at the top of the address space; the next address wraps.
    add_vector(CMD_EXEC, 16'hFFFF, 32'hFFFF_FFFE, 32'd0, 1, 32'h0000_0000, 1'b1);
    add_vector(CMD_EXEC, 16'h557D, 32'h0000_0100, 32'd0, 0, 32'd0, 1'b0); // c.li x10, -1
    add_vector(CMD_EXEC, 16'h7581, 32'h0000_0104, 32'd0, 0, 32'd0, 1'b0); // c.lui x11
    add_vector(CMD_EXEC, 16'h7101, 32'h0000_0108, 32'd0, 0, 32'd0, 1'b0); // c.addi16sp -512
    add_vector(CMD_EXEC, 16'h1FE0, 32'h0000_010C, 32'd0, 0, 32'd0, 1'b0); // c.addi4spn 1020
    add_vector(CMD_EXEC, 16'hDC68, 32'h0000_0110, 32'd0, 0, 32'd0, 1'b0); // c.sw x10
    add_vector(CMD_EXEC, 16'h5C64, 32'h0000_0114, 32'd0, 0, 32'd0, 1'b0); // c.lw x9
    // Move from a register whose load is still outstanding sees the old value.
    add_vector(CMD_EXEC, 16'h8626, 32'h0000_0118, 32'd0, 0, 32'd0, 1'b0); // c.mv x12, x9
    add_vector(CMD_LOAD_RET, 16'h0000, 32'h0000_0000, 32'h8000_0001, 1, 32'd0, 1'b0);
    add_vector(CMD_EXEC, 16'h84FD, 32'h0000_011C, 32'd0, 0, 32'd0, 1'b0); // c.srai x9, 31
    // Shift amount with bit 5 set is illegal on RV32.
    add_vector(CMD_EXEC, 16'h9005, 32'h0000_1000, 32'd0, 1, 32'h0000_1002, 1'b1);
    add_vector(CMD_EXEC, 16'h98FD, 32'h0000_0120, 32'd0, 0, 32'd0, 1'b0); // c.andi x9, -1
    add_vector(CMD_EXEC, 16'h8C89, 32'h0000_0124, 32'd0, 0, 32'd0, 1'b0); // c.sub
    add_vector(CMD_EXEC, 16'h8CA9, 32'h0000_0128, 32'd0, 0, 32'd0, 1'b0); // c.xor
    add_vector(CMD_EXEC, 16'h8CC9, 32'h0000_012C, 32'd0, 0, 32'd0, 1'b0); // c.or
    add_vector(CMD_EXEC, 16'h8CE9, 32'h0000_0130, 32'd0, 0, 32'd0, 1'b0); // c.and
    // Add of zero immediate runs as a no-op.
    add_vector(CMD_EXEC, 16'h0501, 32'h0000_2000, 32'd0, 1, 32'h0000_2002, 1'b0);
    // Jump-and-link by the most negative offset from an odd address.
    add_vector(CMD_EXEC, 16'h3001, 32'h0000_0FFF, 32'd0, 0, 32'd0, 1'b0);
    add_vector(CMD_EXEC, 16'hBFFD, 32'h0000_0200, 32'd0, 0, 32'd0, 1'b0); // c.j -2
    add_vector(CMD_EXEC, 16'hD281, 32'h0000_0300, 32'd0, 0, 32'd0, 1'b0); // c.beqz x13
    add_vector(CMD_EXEC, 16'hECFD, 32'h0000_0400, 32'd0, 0, 32'd0, 1'b0); // c.bnez x9
    add_vector(CMD_EXEC, 16'h057E, 32'h0000_0500, 32'd0, 0, 32'd0, 1'b0); // c.slli x10, 31
    // Stack load into x0 is reserved.
    add_vector(CMD_EXEC, 16'h4002, 32'h0000_3000, 32'd0, 1, 32'h0000_3002, 1'b1);
    add_vector(CMD_EXEC, 16'h5FFE, 32'h0000_0600, 32'd0, 0, 32'd0, 1'b0); // c.lwsp x31
    // Jump-and-link through x1: target read before the link write, bit 0 cleared.
    add_vector(CMD_EXEC, 16'h9082, 32'h0000_0700, 32'd0, 0, 32'd0, 1'b0);
    add_vector(CMD_EXEC, 16'h902A, 32'h0000_0800, 32'd0, 0, 32'd0, 1'b0); // c.add x0 hint
    add_vector(CMD_EXEC, 16'hDFFE, 32'h0000_0900, 32'd0, 0, 32'd0, 1'b0); // c.swsp x31
    // Breakpoint is not supported.
    add_vector(CMD_EXEC, 16'h9002, 32'h7FFF_FFFE, 32'd0, 1, 32'h8000_0000, 1'b1);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (vectors[i]) send_request(vectors[i].stim, vectors[i].typed, vectors[i].want);

    // Random part, with a stretch in the middle where neither side idles.
    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
      calm <= (n >= 600 && n < 900);
      it = random_request();
      send_request(it, 1'b0, '0);
    end
    in_if.valid <= 1'b0;
    calm        <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_rv32c_compressed_execute: PASS");
    end else begin
      $display("tb_rv32c_compressed_execute: FAIL");
    end
    $finish;
  end

endmodule
